[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the port checker mlfb_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define MLFB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also watches the reset cycles
`define MLFB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/mlfb_pkg.sv]
// ----------------------------------------------------------------------------
// mlfb_pkg
// Geometry, codes, lookup tables and shared types of the frame buffer engine.
// ----------------------------------------------------------------------------
package mlfb_pkg;

   localparam int COLUMNS = 84;
   localparam int BANKS   = 6;
   localparam int ROWS    = BANKS * 8;
   localparam int DEPTH   = COLUMNS * BANKS;

   localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [7:0] CURSOR_X_MASK = 8'h7F;

   typedef logic [COL_W-1:0]  col_type;
   typedef logic [BANK_W-1:0] bank_type;
   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic [2:0] {
      OP_PLOT    = 3'd0,
      OP_GLYPH   = 3'd1,
      OP_ADVANCE = 3'd2,
      OP_CURSOR  = 3'd3,
      OP_CLEAR   = 3'd4,
      OP_READ    = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      KIND_DONE,
      KIND_PIXEL,
      KIND_READ,
      KIND_CLEAR
   } kind_type;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_MODIFY,
      ST_HOLD
   } state_type;

   // what one word asks of the store and the cursor
   typedef struct packed {
      kind_type   kind;
      addr_type   addr0;
      addr_type   addr1;
      logic [7:0] mask0;
      logic [7:0] val0;
      logic [7:0] mask1;
      logic [7:0] val1;
      logic       toggle;
      logic       second;
      logic       status;
      logic       cursor_we;
      logic [7:0] cursor_x;
      row_type    cursor_y;
   } plan_type;

   typedef col_type col_lut_type [256];
   typedef row_type row_lut_type [256];

   function automatic col_lut_type build_col_lut();
      col_lut_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = col_type'(i % COLUMNS);
      end
      return t;
   endfunction

   function automatic row_lut_type build_row_lut();
      row_lut_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = row_type'(i % ROWS);
      end
      return t;
   endfunction

   // byte value wrapped into the column and pixel row ranges
   localparam col_lut_type COL_LUT = build_col_lut();
   localparam row_lut_type ROW_LUT = build_row_lut();

   function automatic addr_type entry_addr(bank_type bank, col_type col);
      return addr_type'(32'(bank) * COLUMNS + 32'(col));
   endfunction

endpackage

[rtl/core/mono_lcd_framebuffer_engine.sv]
// ----------------------------------------------------------------------------
// mono_lcd_framebuffer_engine
// Page-organised monochrome frame buffer: pixel plot, glyph columns at a text
// cursor, clear and byte read-back, all held in one synchronous byte store.
// ----------------------------------------------------------------------------
//  channel | dir | words
//  req_    | in  | tuser opcode; tdata x, y, color, column bits, column height
//  rsp_    | out | tdata stored byte (zero unless a read); tuser status
//
//  Plot and in-range read: store read at accept, then for a plot modify and write back.
//  Glyph column: its second bank read during the first write. Cursor ops, spare opcodes
//  and out-of-range reads: no store access. Clear: a pass over all DEPTH entries (504
//  at 84 x 6), one store write a cycle through the single write port. After reset the
//  same pass runs with req_tready low. A result waits in the output register, one more
//  in a holding register; then no new word is taken until the output moves.
// ----------------------------------------------------------------------------
module mono_lcd_framebuffer_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // x_coord, y_coord, color, column_bits, column_height
   input  logic [2:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // read_data
   output logic [0:0]  rsp_tuser    // status
);
   import mlfb_pkg::*;

   logic [7:0] pixel_store [DEPTH];

   plan_type   plan;
   state_type  state_ff, state_in;
   plan_type   job_ff, job_in;
   logic       pass_ff, pass_in;
   logic       fwd_ff, fwd_in;
   logic [7:0] fwd_data_ff, fwd_data_in;
   addr_type   sweep_ff, sweep_in;
   logic       sweep_rsp_ff, sweep_rsp_in;
   logic [7:0] rd_ff;
   logic [7:0] hold_data_ff;
   logic       hold_status_ff;
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic       rsp_status_ff;
   logic [7:0] cursor_x_ff;
   row_type    cursor_y_ff;

   logic       req_ready;
   logic       accept;
   logic       slot_free;
   logic       mem_re, mem_we;
   addr_type   mem_raddr, mem_waddr;
   logic [7:0] mem_wdata;
   logic       fin, fin_status;
   logic [7:0] fin_data;
   addr_type   mod_addr;
   logic [7:0] mod_mask, mod_val, mod_cur, mod_word;

   mlfb_decode u_decode (
      .opcode        (req_tuser),
      .x_coord       (req_tdata[7:0]),
      .y_coord       (req_tdata[15:8]),
      .color         (req_tdata[17:16]),
      .column_bits   (req_tdata[25:18]),
      .column_height (req_tdata[29:26]),
      .cursor_x      (cursor_x_ff),
      .cursor_y      (cursor_y_ff),
      .plan          (plan)
   );

   assign req_tready = req_ready;
   assign accept     = req_tvalid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // second pass may hit the byte just written: take it from the forward path
   assign mod_addr = pass_ff ? job_ff.addr1 : job_ff.addr0;
   assign mod_mask = pass_ff ? job_ff.mask1 : job_ff.mask0;
   assign mod_val  = pass_ff ? job_ff.val1 : job_ff.val0;
   assign mod_cur  = (pass_ff && fwd_ff) ? fwd_data_ff : rd_ff;
   assign mod_word = job_ff.toggle ? (mod_cur ^ mod_mask) :
                     ((mod_cur & ~mod_mask) | (mod_val & mod_mask));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_store[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= pixel_store[mem_raddr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      pass_in      = pass_ff;
      fwd_in       = fwd_ff;
      fwd_data_in  = fwd_data_ff;
      sweep_in     = sweep_ff;
      sweep_rsp_in = sweep_rsp_ff;
      req_ready    = 1'b0;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      fin          = 1'b0;
      fin_data     = '0;
      fin_status   = 1'b0;
      case (state_ff)
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            if (sweep_ff == addr_type'(DEPTH - 1)) begin
               sweep_rsp_in = 1'b0;
               if (sweep_rsp_ff) begin
                  fin = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               sweep_in = addr_type'(sweep_ff + 1'b1);
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_tvalid) begin
               job_in  = plan;
               pass_in = 1'b0;
               case (plan.kind)
                  KIND_PIXEL, KIND_READ: begin
                     mem_re    = 1'b1;
                     mem_raddr = plan.addr0;
                     state_in  = ST_MODIFY;
                  end
                  KIND_CLEAR: begin
                     sweep_in     = '0;
                     sweep_rsp_in = 1'b1;
                     state_in     = ST_SWEEP;
                  end
                  default: begin
                     fin        = 1'b1;
                     fin_status = plan.status;
                  end
               endcase
            end
         end
         ST_MODIFY: begin
            mem_we    = (job_ff.kind == KIND_PIXEL);
            mem_waddr = mod_addr;
            mem_wdata = mod_word;
            if (!pass_ff && job_ff.second) begin
               mem_re      = 1'b1;
               mem_raddr   = job_ff.addr1;
               pass_in     = 1'b1;
               fwd_in      = (job_ff.addr1 == job_ff.addr0);
               fwd_data_in = mod_word;
            end else begin
               fin        = 1'b1;
               fin_data   = (job_ff.kind == KIND_READ) ? mod_cur : 8'h00;
               fin_status = job_ff.status;
            end
         end
         ST_HOLD: begin
            fin        = 1'b1;
            fin_data   = hold_data_ff;
            fin_status = hold_status_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (fin) begin
         state_in = slot_free ? ST_IDLE : ST_HOLD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         pass_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         pass_ff      <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      fwd_ff      <= fwd_in;
      fwd_data_ff <= fwd_data_in;
      if (fin && !slot_free) begin
         hold_data_ff   <= fin_data;
         hold_status_ff <= fin_status;
      end
      if (fin && slot_free) begin
         rsp_data_ff   <= fin_data;
         rsp_status_ff <= fin_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
      end else if (accept && plan.cursor_we) begin
         cursor_x_ff <= plan.cursor_x;
         cursor_y_ff <= plan.cursor_y;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

[rtl/core/mlfb_decode.sv]
// ----------------------------------------------------------------------------
// mlfb_decode
// Turns one request word and the text cursor into store accesses, byte masks
// and the cursor update.
// ----------------------------------------------------------------------------
module mlfb_decode (
   input  logic [2:0]         opcode,
   input  logic [7:0]         x_coord,
   input  logic [7:0]         y_coord,
   input  logic [1:0]         color,
   input  logic [7:0]         column_bits,
   input  logic [3:0]         column_height,
   input  logic [7:0]         cursor_x,
   input  mlfb_pkg::row_type  cursor_y,
   output mlfb_pkg::plan_type plan
);
   import mlfb_pkg::*;

   col_type     plot_col;
   row_type     plot_row;
   bank_type    plot_bank;
   logic [7:0]  plot_mask;
   col_type     glyph_col;
   bank_type    glyph_bank0;
   bank_type    glyph_bank1;
   logic [7:0]  glyph_hmask;
   logic [15:0] glyph_mask16;
   logic [15:0] glyph_val16;
   logic        read_ok;
   logic        cursor_ok;

   assign plot_col  = COL_LUT[x_coord];
   assign plot_row  = ROW_LUT[y_coord];
   assign plot_bank = bank_type'(plot_row >> 3);
   assign plot_mask = 8'(8'd1 << plot_row[2:0]);

   // a glyph column spans at most two banks; the lower one wraps to the top
   assign glyph_col   = COL_LUT[cursor_x];
   assign glyph_bank0 = bank_type'(cursor_y >> 3);
   assign glyph_bank1 = (glyph_bank0 == bank_type'(BANKS - 1)) ? '0 :
                        bank_type'(glyph_bank0 + 1'b1);

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         glyph_hmask[j] = (4'(j) < column_height);
      end
   end

   assign glyph_mask16 = {8'h00, glyph_hmask} << cursor_y[2:0];
   assign glyph_val16  = {8'h00, column_bits & glyph_hmask} << cursor_y[2:0];

   assign read_ok   = (x_coord < 8'(COLUMNS)) && (y_coord < 8'(BANKS));
   assign cursor_ok = (x_coord < 8'(COLUMNS)) && (y_coord < 8'(ROWS));

   always_comb begin
      plan           = '0;
      plan.kind      = KIND_DONE;
      plan.cursor_x  = cursor_x;
      plan.cursor_y  = cursor_y;
      case (opcode)
         OP_PLOT: begin
            plan.kind   = KIND_PIXEL;
            plan.addr0  = entry_addr(plot_bank, plot_col);
            plan.mask0  = plot_mask;
            plan.val0   = color[0] ? plot_mask : 8'h00;
            plan.toggle = color[1];
         end
         OP_GLYPH: begin
            plan.kind      = KIND_PIXEL;
            plan.addr0     = entry_addr(glyph_bank0, glyph_col);
            plan.addr1     = entry_addr(glyph_bank1, glyph_col);
            plan.mask0     = glyph_mask16[7:0];
            plan.val0      = glyph_val16[7:0];
            plan.mask1     = glyph_mask16[15:8];
            plan.val1      = glyph_val16[15:8];
            plan.second    = 1'b1;
            plan.cursor_we = 1'b1;
            plan.cursor_x  = cursor_x + 8'd1;
         end
         OP_ADVANCE: begin
            plan.cursor_we = 1'b1;
            plan.cursor_x  = cursor_x + 8'd1;
         end
         OP_CURSOR: begin
            plan.status    = !cursor_ok;
            plan.cursor_we = cursor_ok;
            plan.cursor_x  = x_coord & CURSOR_X_MASK;
            plan.cursor_y  = row_type'(y_coord);
         end
         OP_CLEAR: begin
            plan.kind = KIND_CLEAR;
         end
         OP_READ: begin
            plan.kind   = read_ok ? KIND_READ : KIND_DONE;
            plan.addr0  = entry_addr(bank_type'(y_coord), col_type'(x_coord));
            plan.status = !read_ok;
         end
         default: begin
            plan.kind = KIND_DONE;
         end
      endcase
   end

endmodule

[rtl/core/mlfb_checker.sv]
// ----------------------------------------------------------------------------
// mlfb_checker
// Port-level checks of the frame buffer engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlfb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [0:0]  rsp_tuser
);
   import mlfb_pkg::*;

   logic req_take;

   assign req_take = req_tvalid && req_tready && (req_tdata[31:30] == req_tdata[31:30]);

   `MLFB_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result word changed while stalled")
   `MLFB_ASSERT_ALWAYS(a_reset_sweep, clock, reset |=> !req_tready, "request taken during clearing pass")
   `MLFB_ASSERT(a_clear_busy, clock, reset, req_take && req_tuser == OP_CLEAR |=> !req_tready, "request taken during clear")
   `MLFB_ASSERT(a_plot_busy, clock, reset, req_take && req_tuser == OP_PLOT |=> !req_tready, "request taken during pixel write-back")
   `MLFB_ASSERT(a_advance_result, clock, reset, req_take && req_tuser == OP_ADVANCE |=> rsp_tvalid, "cursor advance gave no result word")

endmodule

bind mono_lcd_framebuffer_engine mlfb_checker u_mlfb_checker (.*);

[dv/mono_lcd_framebuffer_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mono_lcd_framebuffer_checker
// Watches both stream channels of the frame buffer engine, keeps its own copy
// of the byte store and the text cursor, works out the reply to every
// accepted command word and compares each returned word with the oldest one.
// ----------------------------------------------------------------------------
module mono_lcd_framebuffer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // x_coord, y_coord, color, column_bits, column_height
   input  logic [2:0]  req_tuser,   // opcode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // read_data
   input  logic [0:0]  rsp_tuser,   // status
   output int          mismatch_count,
   output int          outstanding
);
   import mlfb_pkg::*;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_IGNORED = 1'b1;

   typedef struct packed {
      logic [7:0] data;
      logic       status;
   } reply_type;

   logic [7:0] shadow_store [DEPTH];
   logic [7:0] shadow_cursor_x;
   row_type    shadow_cursor_y;
   reply_type  expected_replies [$];

   function automatic void paint_pixel(int unsigned x, int unsigned y, logic flip, logic on);
      int unsigned col;
      int unsigned row;
      int unsigned idx;
      logic [7:0]  mask;
      col  = x % COLUMNS;
      row  = y % ROWS;
      idx  = (row / 8) * COLUMNS + col;
      mask = 8'h01 << (row % 8);
      if (flip) begin
         shadow_store[idx] = shadow_store[idx] ^ mask;
      end else if (on) begin
         shadow_store[idx] = shadow_store[idx] | mask;
      end else begin
         shadow_store[idx] = shadow_store[idx] & ~mask;
      end
   endfunction

   function automatic reply_type apply_command(logic [2:0] op, logic [31:0] fields);
      logic [7:0]  x;
      logic [7:0]  y;
      logic [1:0]  color;
      logic [7:0]  bits;
      logic [3:0]  height;
      int unsigned rows_drawn;
      reply_type   reply;
      x      = fields[7:0];
      y      = fields[15:8];
      color  = fields[17:16];
      bits   = fields[25:18];
      height = fields[29:26];
      reply  = '{data: 8'h00, status: STATUS_DONE};
      case (op)
         OP_PLOT: begin
            // upper colour bit toggles, so colour three toggles as well
            paint_pixel(32'(x), 32'(y), color[1], color[0]);
         end
         OP_GLYPH: begin
            rows_drawn = (height > 4'd8) ? 8 : 32'(height);
            for (int j = 0; j < rows_drawn; j++) begin
               paint_pixel(32'(shadow_cursor_x), 32'(shadow_cursor_y) + j, 1'b0, bits[j]);
            end
            shadow_cursor_x = shadow_cursor_x + 8'd1;
         end
         OP_ADVANCE: begin
            shadow_cursor_x = shadow_cursor_x + 8'd1;
         end
         OP_CURSOR: begin
            if (x < COLUMNS && y < ROWS) begin
               shadow_cursor_x = x & CURSOR_X_MASK;
               shadow_cursor_y = row_type'(y);
            end else begin
               reply.status = STATUS_IGNORED;
            end
         end
         OP_CLEAR: begin
            foreach (shadow_store[i]) shadow_store[i] = 8'h00;
         end
         OP_READ: begin
            if (x < COLUMNS && y < BANKS) begin
               reply.data = shadow_store[y * COLUMNS + x];
            end else begin
               reply.status = STATUS_IGNORED;
            end
         end
         default: begin
            // spare opcodes do nothing
         end
      endcase
      return reply;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         foreach (shadow_store[i]) shadow_store[i] = 8'h00;
         shadow_cursor_x = 8'h00;
         shadow_cursor_y = '0;
         expected_replies.delete();
      end else begin
         // retire the returned word before taking the new command
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               mismatch_count++;
               $error("reply word with nothing expected: read_data %0h status %0d",
                      rsp_tdata, rsp_tuser);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_tdata !== want.data) begin
                  mismatch_count++;
                  $error("read_data: expected %0h, got %0h", want.data, rsp_tdata);
               end
               if (rsp_tuser[0] !== want.status) begin
                  mismatch_count++;
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser[0]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_replies.push_back(apply_command(req_tuser, req_tdata));
         end
      end
      outstanding <= expected_replies.size();
   end

endmodule

[dv/tb_mono_lcd_framebuffer_engine.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mono_lcd_framebuffer_engine
// Drives command words into the frame buffer engine: a directed opening over
// the edge cases, then random drawing, read-back and text-cursor runs with
// random gaps on both channels, a long reply stall and a full drain. The
// checker beside the engine predicts every reply and counts mismatches.
// ----------------------------------------------------------------------------
module tb_mono_lcd_framebuffer_engine;
   import mlfb_pkg::*;

   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   localparam logic [1:0] PAINT_CLEAR    = 2'd0;
   localparam logic [1:0] PAINT_SET      = 2'd1;
   localparam logic [1:0] PAINT_FLIP     = 2'd2;
   localparam logic [1:0] PAINT_FLIP_ALT = 2'd3;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SQUEEZE_CYCLES = 80;
   localparam int SETTLE_CYCLES  = 20;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [0:0]  rsp_tuser;

   int mismatch_count;
   int outstanding;
   int idle_cycles;

   bit calm;
   bit sender_rush;
   bit squeeze_req;
   bit squeeze_taken;

   logic [7:0] last_plot_x;
   logic [7:0] last_plot_y;

   mono_lcd_framebuffer_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   mono_lcd_framebuffer_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic drive_command(input logic [2:0] op, input logic [7:0] x, input logic [7:0] y,
                                input logic [1:0] color, input logic [7:0] bits,
                                input logic [3:0] height);
      int gap;
      req_tuser  <= op;
      req_tdata  <= {2'b00, height, bits, color, y, x};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      gap = sender_rush ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic send_random_command();
      int         r;
      logic [2:0] op;
      logic [7:0] x;
      logic [7:0] y;
      logic [3:0] height;
      r      = $urandom_range(0, 99);
      x      = 8'($urandom_range(0, 255));
      y      = 8'($urandom_range(0, 255));
      height = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 8)) :
                                            4'($urandom_range(0, 15));
      if (r < 28) begin
         op = OP_PLOT;
         last_plot_x = x;
         last_plot_y = y;
      end else if (r < 48) begin
         op = OP_GLYPH;
      end else if (r < 54) begin
         op = OP_ADVANCE;
      end else if (r < 66) begin
         op = OP_CURSOR;
         if ($urandom_range(0, 9) < 7) begin
            x = 8'($urandom_range(0, COLUMNS - 1));
            y = 8'($urandom_range(0, ROWS - 1));
         end
      end else if (r < 68) begin
         op = OP_CLEAR;
      end else if (r < 96) begin
         op = OP_READ;
         r  = $urandom_range(0, 99);
         // read back the byte under the last plotted pixel
         if (r < 50) begin
            x = 8'(last_plot_x % COLUMNS);
            y = 8'((last_plot_y % ROWS) / 8);
         end else if (r < 85) begin
            x = 8'($urandom_range(0, COLUMNS - 1));
            y = 8'($urandom_range(0, BANKS - 1));
         end
      end else begin
         op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
      end
      drive_command(op, x, y, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), height);
   endtask

   // reply side: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      int run_left;
      stall_left = 0;
      run_left   = 0;
      forever begin
         @(posedge clock);
         if (squeeze_req && !squeeze_taken) begin
            squeeze_taken = 1'b1;
            stall_left    = SQUEEZE_CYCLES;
         end else if (stall_left == 0 && run_left == 0) begin
            stall_left = pick_gap();
            run_left   = $urandom_range(1, 8);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (run_left > 0) run_left--;
         end
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      last_plot_x = 8'd0;
      last_plot_y = 8'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed opening
      drive_command(OP_READ,    8'd0,   8'd0,   PAINT_CLEAR,    8'h00, 4'd0);
      drive_command(OP_PLOT,    8'd0,   8'd0,   PAINT_SET,      8'hFF, 4'd15);
      drive_command(OP_PLOT,    8'd255, 8'd255, PAINT_SET,      8'h00, 4'd0);
      drive_command(OP_READ,    8'd3,   8'd1,   PAINT_CLEAR,    8'h00, 4'd0);
      drive_command(OP_PLOT,    8'd0,   8'd0,   PAINT_CLEAR,    8'h00, 4'd0);
      drive_command(OP_PLOT,    8'd83,  8'd47,  PAINT_FLIP,     8'h00, 4'd0);
      drive_command(OP_PLOT,    8'd83,  8'd46,  PAINT_FLIP_ALT, 8'h00, 4'd0);
      drive_command(OP_READ,    8'd83,  8'd5,   PAINT_CLEAR,    8'h00, 4'd0);
      drive_command(OP_CURSOR,  8'd83,  8'd47,  PAINT_CLEAR,    8'h00, 4'd0);
      // glyph taller than eight rows, wrapping past the bottom row
      drive_command(OP_GLYPH,   8'd0,   8'd0,   PAINT_CLEAR,    8'hFF, 4'd15);
      drive_command(OP_READ,    8'd83,  8'd0,   PAINT_CLEAR,    8'h00, 4'd0);
      drive_command(OP_ADVANCE, 8'd0,   8'd0,   PAINT_CLEAR,    8'h00, 4'd0);
      drive_command(OP_CURSOR,  8'd84,  8'd0,   PAINT_CLEAR,    8'h00, 4'd0);
      drive_command(OP_CURSOR,  8'd0,   8'd48,  PAINT_CLEAR,    8'h00, 4'd0);
      drive_command(OP_CURSOR,  8'd255, 8'd255, PAINT_CLEAR,    8'h00, 4'd0);
      drive_command(OP_CURSOR,  8'd10,  8'd37,  PAINT_CLEAR,    8'h00, 4'd0);
      drive_command(OP_GLYPH,   8'd0,   8'd0,   PAINT_CLEAR,    8'hA5, 4'd8);
      drive_command(OP_GLYPH,   8'd0,   8'd0,   PAINT_CLEAR,    8'h5A, 4'd0);
      drive_command(OP_GLYPH,   8'd0,   8'd0,   PAINT_CLEAR,    8'hFF, 4'd3);
      drive_command(OP_READ,    8'd10,  8'd4,   PAINT_CLEAR,    8'h00, 4'd0);
      drive_command(OP_READ,    8'd10,  8'd5,   PAINT_CLEAR,    8'h00, 4'd0);
      drive_command(OP_READ,    8'd84,  8'd0,   PAINT_CLEAR,    8'h00, 4'd0);
      drive_command(OP_READ,    8'd0,   8'd6,   PAINT_CLEAR,    8'h00, 4'd0);
      drive_command(OP_READ,    8'd255, 8'd255, PAINT_CLEAR,    8'h00, 4'd0);
      drive_command(OP_SPARE_A, 8'd255, 8'd255, PAINT_FLIP_ALT, 8'hFF, 4'd15);
      drive_command(OP_SPARE_B, 8'd1,   8'd1,   PAINT_SET,      8'h01, 4'd1);
      drive_command(OP_CLEAR,   8'd0,   8'd0,   PAINT_CLEAR,    8'h00, 4'd0);
      drive_command(OP_READ,    8'd3,   8'd1,   PAINT_CLEAR,    8'h00, 4'd0);

      repeat (200) send_random_command();

      // hold the sender until the engine has returned everything
      wait_for_drain();

      // stall the reply side long enough for the engine to back up
      squeeze_req = 1'b1;
      while (!squeeze_taken) @(posedge clock);
      sender_rush = 1'b1;
      repeat (40) send_random_command();
      sender_rush = 1'b0;

      calm = 1'b1;
      repeat (100) send_random_command();
      calm = 1'b0;

      // a long run of text past the cursor wrap at 255
      drive_command(OP_CURSOR, 8'd83, 8'($urandom_range(0, ROWS - 1)), PAINT_CLEAR,
                    8'h00, 4'd0);
      for (int i = 0; i < 200; i++) begin
         if (i % 10 == 9) begin
            drive_command(OP_READ, 8'($urandom_range(0, COLUMNS - 1)),
                          8'($urandom_range(0, BANKS - 1)), PAINT_CLEAR, 8'h00, 4'd0);
         end else if ($urandom_range(0, 9) < 7) begin
            drive_command(OP_GLYPH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          4'($urandom_range(0, 8)));
         end else begin
            drive_command(OP_ADVANCE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          4'($urandom_range(0, 15)));
         end
      end

      repeat (60) send_random_command();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
